// File: src/waterfall_level_colormap_assert.svh
// Assertion macros shared by the waterfall level colormap checks.
`ifndef WATERFALL_LEVEL_COLORMAP_ASSERT_SVH
`define WATERFALL_LEVEL_COLORMAP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define WLC_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("waterfall_level_colormap check failed");

// Consequent must hold in the cycle after the antecedent, outside reset.
`define WLC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("waterfall_level_colormap check failed");

// Consequent must hold in the cycle after reset is sampled high.
`define WLC_ASSERT_RESET(name, cons) \
  name: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("waterfall_level_colormap reset check failed");

`endif

// File: src/wlc_pkg.sv
// Shared types, register codes and gradient tables of the waterfall level colormap.
package wlc_pkg;

  localparam int LEVEL_BITS_DEFAULT = 13;
  localparam int FRAC_BITS_DEFAULT  = 16;
  localparam int QUEUE_DEPTH        = 4;

  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_SCHEME = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AUTO_BLACK   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CONTRAST     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLACK_SHIFT  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FLOOR_LEVEL  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NOISE_FLOOR  = 3'd5;

  typedef logic [2:0] scheme_t;
  localparam int NUM_SCHEMES = 5;
  localparam scheme_t SCHEME_DEFAULT    = 3'd0;
  localparam scheme_t SCHEME_GRAY       = 3'd1;
  localparam scheme_t SCHEME_BLUE_GREEN = 3'd2;
  localparam scheme_t SCHEME_FIRE       = 3'd3;
  localparam scheme_t SCHEME_PLASMA     = 3'd4;

  // The widest span is 120 dB in units of 1/1600 dB.
  localparam int SPAN_BITS = 18;

  typedef struct packed {
    logic [SPAN_BITS-1:0] delta;
    logic [SPAN_BITS-1:0] span;
    logic                 t_zero;
    logic                 t_one;
    scheme_t              scheme;
  } item_t;

  localparam int NUM_STOPS       = 24;
  localparam int STOP_IDX_BITS   = 5;
  localparam int MAX_INNER_STOPS = 5;
  localparam int NUM_CHANNELS    = 3;

  localparam logic [6:0] STOP_HUND [NUM_STOPS] = '{
    0, 15, 30, 45, 60, 80, 100,
    0, 100,
    0, 25, 50, 75, 100,
    0, 25, 50, 75, 100,
    0, 25, 50, 75, 100
  };

  localparam logic [7:0] STOP_COLOR [NUM_STOPS][NUM_CHANNELS] = '{
    '{0, 0, 0}, '{0, 0, 128}, '{0, 64, 255}, '{0, 200, 255},
    '{0, 220, 0}, '{255, 255, 0}, '{255, 0, 0},
    '{0, 0, 0}, '{255, 255, 255},
    '{0, 0, 0}, '{0, 30, 120}, '{0, 100, 180}, '{0, 200, 130}, '{220, 255, 220},
    '{0, 0, 0}, '{128, 0, 0}, '{220, 80, 0}, '{255, 200, 0}, '{255, 255, 220},
    '{0, 0, 0}, '{80, 0, 140}, '{200, 0, 120}, '{240, 120, 0}, '{255, 255, 80}
  };

  localparam logic [STOP_IDX_BITS-1:0] TAB_FIRST [NUM_SCHEMES] = '{0, 7, 9, 14, 19};
  localparam logic [2:0]               TAB_COUNT [NUM_SCHEMES] = '{7, 2, 5, 5, 5};

  // Stop position in hundredths rounded to a fraction with frac bits.
  function automatic int stop_pos(input int hund, input int frac);
    return (hund * (1 << frac) + 50) / 100;
  endfunction

endpackage

// File: src/waterfall_level_colormap.sv
// Top level of the waterfall level colormap: front end, item queue and back end.
// Throughput: one item per cycle while out_stall is low; divider and lookup are pipelined.
// The queue keeps taking input, until it is full, while a finished result waits on out_stall.
// Synchronous reset empties the queue and pipeline and restores register defaults.
module waterfall_level_colormap #(
  parameter int LEVEL_BITS  = wlc_pkg::LEVEL_BITS_DEFAULT,
  parameter int FRAC_BITS   = wlc_pkg::FRAC_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = wlc_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [LEVEL_BITS-1:0]       level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue,
  input  logic                               cfg_write,
  input  logic [wlc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [LEVEL_BITS-1:0]              cfg_data
);
  import wlc_pkg::*;

  logic  q_full;
  logic  q_push;
  item_t q_in;
  logic  q_pop;
  item_t q_head;
  logic  q_not_empty;

  wlc_front #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .level     (level),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .full      (q_full),
    .push      (q_push),
    .item      (q_in)
  );

  wlc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty)
  );

  wlc_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_item    (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule

// File: src/wlc_front.sv
// Front end: configuration registers, input transfer and window classification.
module wlc_front #(
  parameter int LEVEL_BITS = wlc_pkg::LEVEL_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [LEVEL_BITS-1:0]       level,
  input  logic                               cfg_write,
  input  logic [wlc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [LEVEL_BITS-1:0]              cfg_data,
  input  logic                               full,
  output logic                               push,
  output wlc_pkg::item_t                     item
);
  import wlc_pkg::*;

  localparam int DW = LEVEL_BITS + 10;

  localparam int GAIN_MAX       = 100;
  localparam int GAIN_RESET     = 50;
  localparam int BLACK_RESET    = 50;
  localparam int FLOOR_RESET    = -1920;
  localparam int LEVEL_SCALE    = 100;
  localparam int BLACK_BIAS     = 125;
  localparam int BLACK_STEP     = 640;
  localparam int AUTO_SPAN_BASE = 192000;
  localparam int AUTO_SPAN_STEP = 1456;
  localparam int AUTO_SPAN_MIN  = 1600;
  localparam int MAN_SPAN_BASE  = 128000;
  localparam int MAN_SPAN_STEP  = 1120;

  localparam logic signed [DW-1:0] K_SCALE = DW'(LEVEL_SCALE);
  localparam logic signed [DW-1:0] K_BIAS  = DW'(BLACK_BIAS);
  localparam logic signed [DW-1:0] K_STEP  = DW'(BLACK_STEP);

  scheme_t                      color_scheme;
  logic                         auto_black;
  logic [6:0]                   contrast;
  logic [6:0]                   black_shift;
  logic signed [LEVEL_BITS-1:0] floor_level;
  logic signed [LEVEL_BITS-1:0] noise_floor;

  logic [6:0]           gain;
  logic [6:0]           blk;
  logic signed [DW-1:0] lvl_w;
  logic signed [DW-1:0] blk_w;
  logic signed [DW-1:0] lo;
  logic signed [DW-1:0] delta;
  logic signed [DW-1:0] span_w;
  logic [SPAN_BITS-1:0] span_auto_raw;
  logic [SPAN_BITS-1:0] span_auto;
  logic [SPAN_BITS-1:0] span_man;
  logic [SPAN_BITS-1:0] span;
  logic                 t_zero;
  logic                 t_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_scheme <= SCHEME_DEFAULT;
      auto_black   <= 1'b0;
      contrast     <= 7'(GAIN_RESET);
      black_shift  <= 7'(BLACK_RESET);
      floor_level  <= LEVEL_BITS'(FLOOR_RESET);
      noise_floor  <= LEVEL_BITS'(FLOOR_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLOR_SCHEME: color_scheme <= cfg_data[2:0];
        REG_AUTO_BLACK:   auto_black   <= cfg_data[0];
        REG_CONTRAST:     contrast     <= cfg_data[6:0];
        REG_BLACK_SHIFT:  black_shift  <= cfg_data[6:0];
        REG_FLOOR_LEVEL:  floor_level  <= $signed(cfg_data);
        REG_NOISE_FLOOR:  noise_floor  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    gain  = (contrast > 7'(GAIN_MAX)) ? 7'(GAIN_MAX) : contrast;
    blk   = (black_shift > 7'(GAIN_MAX)) ? 7'(GAIN_MAX) : black_shift;
    lvl_w = DW'(level);
    blk_w = $signed(DW'(blk));

    span_auto_raw = SPAN_BITS'(AUTO_SPAN_BASE) - SPAN_BITS'(AUTO_SPAN_STEP) * SPAN_BITS'(gain);
    span_auto     = (span_auto_raw < SPAN_BITS'(AUTO_SPAN_MIN)) ?
                    SPAN_BITS'(AUTO_SPAN_MIN) : span_auto_raw;
    span_man      = SPAN_BITS'(MAN_SPAN_BASE) - SPAN_BITS'(MAN_SPAN_STEP) * SPAN_BITS'(gain);

    if (auto_black) begin
      lo   = DW'(noise_floor) * K_SCALE;
      span = span_auto;
    end else begin
      lo   = DW'(floor_level) * K_SCALE + (K_BIAS - blk_w) * K_STEP;
      span = span_man;
    end

    delta  = lvl_w * K_SCALE - lo;
    span_w = $signed(DW'(span));
    t_zero = delta[DW-1] || (delta == '0);
    t_one  = !t_zero && (delta >= span_w);
  end

  assign in_stall = full;
  assign push     = in_valid && !full;

  always_comb begin
    item.delta  = (t_zero || t_one) ? '0 : delta[SPAN_BITS-1:0];
    item.span   = span;
    item.t_zero = t_zero;
    item.t_one  = t_one;
    item.scheme = (color_scheme > SCHEME_PLASMA) ? SCHEME_DEFAULT : color_scheme;
  end

endmodule

// File: src/wlc_queue.sv
// Short queue of classified items between the front end and the back end.
module wlc_queue #(
  parameter int DEPTH = wlc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wlc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output wlc_pkg::item_t head,
  output logic           not_empty
);
  import wlc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

endmodule

// File: src/wlc_back.sv
// Back end: pipelined divider for t, gradient segment lookup and channel interpolation.
module wlc_back #(
  parameter int FRAC_BITS = wlc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  wlc_pkg::item_t q_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue
);
  import wlc_pkg::*;

  localparam int TW     = FRAC_BITS + 1;
  localparam int NW     = FRAC_BITS + 9;
  localparam int SW     = TW + 10;
  localparam int QSTEPS = 8;
  localparam int NS     = FRAC_BITS + 12;
  localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

  logic          en;
  logic [NS-1:0] vld;

  logic [TW-1:0] pos_tab [NUM_STOPS];

  logic [SPAN_BITS-1:0] drem  [FRAC_BITS+1];
  logic [SPAN_BITS-1:0] dspan [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] dquo  [FRAC_BITS+1];
  logic                 dzero [FRAC_BITS+1];
  logic                 done  [FRAC_BITS+1];
  scheme_t              dsch  [FRAC_BITS+1];

  logic [TW-1:0] t_t;
  scheme_t       t_sch;

  logic [STOP_IDX_BITS-1:0] first_idx;
  logic [STOP_IDX_BITS-1:0] a_idx;
  logic [STOP_IDX_BITS-1:0] b_idx;
  logic [2:0]               cnt;
  logic [2:0]               seg;

  logic [TW-1:0] s_t;
  logic [TW-1:0] s_p0;
  logic [TW-1:0] s_den;
  logic [7:0]    s_c0 [NUM_CHANNELS];
  logic [7:0]    s_c1 [NUM_CHANNELS];

  logic [NW-1:0] qrem [QSTEPS+1][NUM_CHANNELS];
  logic [7:0]    qquo [QSTEPS+1][NUM_CHANNELS];
  logic [TW-1:0] qden [QSTEPS+1];

  assign en        = !(vld[NS-1] && out_stall);
  assign pop       = en && q_valid;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], pop};
    end
  end

  for (genvar g = 0; g < NUM_STOPS; g++) begin : g_pos
    localparam int P = stop_pos(int'(STOP_HUND[g]), FRAC_BITS);
    assign pos_tab[g] = TW'(P);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0]  <= q_item.delta;
      dspan[0] <= q_item.span;
      dquo[0]  <= '0;
      dzero[0] <= q_item.t_zero;
      done[0]  <= q_item.t_one;
      dsch[0]  <= q_item.scheme;
    end
  end

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    logic [SPAN_BITS:0] shifted;
    logic [SPAN_BITS:0] diff;
    logic               ge;

    assign shifted = {drem[k], 1'b0};
    assign diff    = shifted - {1'b0, dspan[k]};
    assign ge      = shifted >= {1'b0, dspan[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        drem[k+1]  <= ge ? diff[SPAN_BITS-1:0] : shifted[SPAN_BITS-1:0];
        dquo[k+1]  <= {dquo[k][FRAC_BITS-2:0], ge};
        dspan[k+1] <= dspan[k];
        dzero[k+1] <= dzero[k];
        done[k+1]  <= done[k];
        dsch[k+1]  <= dsch[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_sch <= dsch[FRAC_BITS];
      if (dzero[FRAC_BITS]) begin
        t_t <= '0;
      end else if (done[FRAC_BITS]) begin
        t_t <= T_ONE;
      end else begin
        t_t <= {1'b0, dquo[FRAC_BITS]};
      end
    end
  end

  // Stop positions rise within a table, so counting the inner stops below t
  // gives the same segment as a linear search.
  always_comb begin
    first_idx = TAB_FIRST[t_sch];
    cnt       = TAB_COUNT[t_sch];
    seg       = '0;
    for (int k = 1; k <= MAX_INNER_STOPS; k++) begin
      if ((3'(k) + 3'd2 <= cnt) && (pos_tab[first_idx + STOP_IDX_BITS'(k)] < t_t)) begin
        seg = seg + 3'd1;
      end
    end
    a_idx = first_idx + STOP_IDX_BITS'(seg);
    b_idx = a_idx + STOP_IDX_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_t   <= t_t;
      s_p0  <= pos_tab[a_idx];
      s_den <= pos_tab[b_idx] - pos_tab[a_idx];
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        s_c0[ch] <= STOP_COLOR[a_idx][ch];
        s_c1[ch] <= STOP_COLOR[b_idx][ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qden[0] <= s_den;
    end
  end

  for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_num
    logic signed [TW:0]   dt_s;
    logic signed [8:0]    dc_s;
    logic signed [SW-1:0] prod;
    logic [TW+7:0]        base;
    logic signed [SW-1:0] sum;

    always_comb begin
      dt_s = $signed({1'b0, s_t - s_p0});
      dc_s = $signed({1'b0, s_c1[ch]}) - $signed({1'b0, s_c0[ch]});
      prod = dt_s * dc_s;
      base = s_c0[ch] * s_den;
      sum  = $signed({2'b00, base}) + prod;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qrem[0][ch] <= sum[NW-1:0];
        qquo[0][ch] <= '0;
      end
    end
  end

  for (genvar j = 0; j < QSTEPS; j++) begin : g_quo
    always_ff @(posedge clk) begin
      if (en) begin
        qden[j+1] <= qden[j];
      end
    end

    for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_ch
      logic [NW-1:0] trial;
      logic          ge;

      assign trial = NW'(qden[j]) << (QSTEPS - 1 - j);
      assign ge    = qrem[j][ch] >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          qrem[j+1][ch] <= ge ? qrem[j][ch] - trial : qrem[j][ch];
          qquo[j+1][ch] <= qquo[j][ch] | (ge ? (8'd1 << (QSTEPS - 1 - j)) : 8'd0);
        end
      end
    end
  end

  assign red   = qquo[QSTEPS][0];
  assign green = qquo[QSTEPS][1];
  assign blue  = qquo[QSTEPS][2];

endmodule

// File: src/wlc_checker.sv
// Port-level checks of the waterfall level colormap and their bind to the top level.
`include "waterfall_level_colormap_assert.svh"

module wlc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  localparam int PEND_BITS = 8;

  logic                 in_xfer;
  logic                 out_xfer;
  logic [PEND_BITS-1:0] pending;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PEND_BITS'(in_xfer) - PEND_BITS'(out_xfer);
    end
  end

  `WLC_ASSERT_RESET(a_reset_clears, !out_valid && !in_stall)
  `WLC_ASSERT_SAME(a_result_has_source, out_valid, pending != '0)
  `WLC_ASSERT_NEXT(a_valid_holds, out_valid && out_stall, out_valid)
  `WLC_ASSERT_NEXT(a_color_holds, out_valid && out_stall, $stable({red, green, blue}))

endmodule

bind waterfall_level_colormap wlc_checker u_wlc_checker (.*);

// File: tb/tb_waterfall_level_colormap.sv
// Self-checking testbench for the waterfall level colormap with random gaps and stalls.
module tb_waterfall_level_colormap;
  import wlc_pkg::*;

  localparam int LVL_W = LEVEL_BITS_DEFAULT;
  localparam int FRAC_W = FRAC_BITS_DEFAULT;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS = 100;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  localparam int GRAD_HUND [24] = '{
    0, 15, 30, 45, 60, 80, 100,
    0, 100,
    0, 25, 50, 75, 100,
    0, 25, 50, 75, 100,
    0, 25, 50, 75, 100
  };
  localparam int GRAD_RGB [24][3] = '{
    '{0, 0, 0}, '{0, 0, 128}, '{0, 64, 255}, '{0, 200, 255},
    '{0, 220, 0}, '{255, 255, 0}, '{255, 0, 0},
    '{0, 0, 0}, '{255, 255, 255},
    '{0, 0, 0}, '{0, 30, 120}, '{0, 100, 180}, '{0, 200, 130}, '{220, 255, 220},
    '{0, 0, 0}, '{128, 0, 0}, '{220, 80, 0}, '{255, 200, 0}, '{255, 255, 220},
    '{0, 0, 0}, '{80, 0, 140}, '{200, 0, 120}, '{240, 120, 0}, '{255, 255, 80}
  };
  localparam int GRAD_FIRST [NUM_SCHEMES] = '{0, 7, 9, 14, 19};
  localparam int GRAD_COUNT [NUM_SCHEMES] = '{7, 2, 5, 5, 5};

  typedef logic signed [LVL_W-1:0] level_t;
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  class colormap_shadow;
    scheme_t scheme = SCHEME_DEFAULT;
    logic auto_blk = 1'b0;
    logic [6:0] gain = 7'd50;
    logic [6:0] blk = 7'd50;
    level_t floor_lvl = -1920;
    level_t noise_lvl = -1920;
    rgb_t pending_colors[$];
    int mismatches = 0;

    function void write(logic [CFG_INDEX_BITS-1:0] idx, logic [LVL_W-1:0] val);
      case (idx)
        REG_COLOR_SCHEME: scheme = val[2:0];
        REG_AUTO_BLACK: auto_blk = val[0];
        REG_CONTRAST: gain = val[6:0];
        REG_BLACK_SHIFT: blk = val[6:0];
        REG_FLOOR_LEVEL: floor_lvl = val;
        REG_NOISE_FLOOR: noise_lvl = val;
        default: ;
      endcase
    endfunction

    // Window bounds in units of 1/1600 dB.
    function void window(output longint lo, output longint span);
      longint g, k;
      g = (gain > 100) ? 100 : longint'(gain);
      k = (blk > 100) ? 100 : longint'(blk);
      if (auto_blk) begin
        lo = longint'(noise_lvl) * 100;
        span = 192000 - 1456 * g;
        if (span < 1600) span = 1600;
      end else begin
        lo = longint'(floor_lvl) * 100 + (125 - k) * 640;
        span = 128000 - 1120 * g;
      end
    endfunction

    function longint stop_q(int hund);
      return (longint'(hund) * (longint'(1) << FRAC_W) + 50) / 100;
    endfunction

    function logic [7:0] lerp(int c0, int c1, longint t, longint p0, longint p1);
      longint num, v;
      num = c0 * (p1 - p0) + (t - p0) * (c1 - c0);
      v = (num < 0) ? 0 : num / (p1 - p0);
      if (v > 255) v = 255;
      return v[7:0];
    endfunction

    function rgb_t map_level(level_t lv);
      longint lo, span, d, t, p0, p1, one;
      int sch, a, n, i;
      rgb_t c;
      one = longint'(1) << FRAC_W;
      window(lo, span);
      d = longint'(lv) * 100 - lo;
      if (d <= 0) t = 0;
      else if (d >= span) t = one;
      else t = (d * one) / span;
      sch = (scheme < NUM_SCHEMES) ? int'(scheme) : int'(SCHEME_DEFAULT);
      a = GRAD_FIRST[sch];
      n = GRAD_COUNT[sch];
      i = 0;
      while (i + 2 < n && stop_q(GRAD_HUND[a + i + 1]) < t) i++;
      p0 = stop_q(GRAD_HUND[a + i]);
      p1 = stop_q(GRAD_HUND[a + i + 1]);
      c.r = lerp(GRAD_RGB[a + i][0], GRAD_RGB[a + i + 1][0], t, p0, p1);
      c.g = lerp(GRAD_RGB[a + i][1], GRAD_RGB[a + i + 1][1], t, p0, p1);
      c.b = lerp(GRAD_RGB[a + i][2], GRAD_RGB[a + i + 1][2], t, p0, p1);
      return c;
    endfunction

    function level_t near_window();
      longint lo, span, v;
      window(lo, span);
      v = lo / 100 - 8 + longint'($urandom_range(0, int'(span / 100) + 16));
      if (v < -4096) v = -4096;
      if (v > 4095) v = 4095;
      return v[LVL_W-1:0];
    endfunction

    function void accept_level(level_t lv);
      pending_colors.push_back(map_level(lv));
    endfunction

    function void check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      rgb_t c;
      if (pending_colors.size() == 0) begin
        $error("color transfer with no pending level: red %0d green %0d blue %0d", r, g, b);
        mismatches++;
        return;
      end
      c = pending_colors.pop_front();
      if (r !== c.r) begin
        $error("red mismatch: expected %0d, actual %0d", c.r, r);
        mismatches++;
      end
      if (g !== c.g) begin
        $error("green mismatch: expected %0d, actual %0d", c.g, g);
        mismatches++;
      end
      if (b !== c.b) begin
        $error("blue mismatch: expected %0d, actual %0d", c.b, b);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  level_t level = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red, green, blue;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [LVL_W-1:0] cfg_data = '0;

  colormap_shadow shadow = new();
  level_t batch[$];
  bit no_gaps = 1'b0;
  int idle_cycles = 0;

  waterfall_level_colormap dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .level(level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red(red),
    .green(green),
    .blue(blue),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      shadow.check_color(red, green, blue);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [LVL_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    shadow.write(idx, val);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_level(input level_t v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    level <= v;
    do @(posedge clk); while (in_stall);
    shadow.accept_level(v);
  endtask

  task automatic send_batch();
    foreach (batch[k]) send_level(batch[k]);
    in_valid <= 1'b0;
    while (shadow.pending_colors.size() != 0) @(posedge clk);
  endtask

  function automatic logic [LVL_W-1:0] with_stray(logic [LVL_W-1:0] v, int w);
    if ($urandom_range(0, 3) == 0) v = v | LVL_W'($urandom << w);
    return v;
  endfunction

  function automatic logic [LVL_W-1:0] pick_percent();
    case ($urandom_range(0, 5))
      0: return LVL_W'(0);
      1: return LVL_W'(100);
      2: return LVL_W'($urandom_range(101, 127));
      default: return LVL_W'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] pick_level_reg();
    case ($urandom_range(0, 7))
      0: return LVL_W'(-4096);
      1: return LVL_W'(4095);
      default: return LVL_W'(int'($urandom_range(0, 6000)) - 4096);
    endcase
  endfunction

  task automatic randomize_regs();
    write_reg(REG_COLOR_SCHEME, with_stray(LVL_W'($urandom_range(0, 7)), 3));
    write_reg(REG_AUTO_BLACK, with_stray(LVL_W'($urandom_range(0, 1)), 1));
    write_reg(REG_CONTRAST, with_stray(pick_percent(), 7));
    write_reg(REG_BLACK_SHIFT, with_stray(pick_percent(), 7));
    write_reg(REG_FLOOR_LEVEL, pick_level_reg());
    write_reg(REG_NOISE_FLOOR, pick_level_reg());
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_LO, LVL_W'($urandom));
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_HI, LVL_W'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset window spans levels -1440 to -720; the stop boundaries fall inside it.
    batch = '{-4096, 4095, 0, -1, -1440, -1439, -720, -721, -1332, -1331,
              -1224, -1116, -1008, -864};
    send_batch();

    write_reg(REG_COLOR_SCHEME, 13'h1FF9);
    write_reg(REG_SPARE_LO, 13'h1ABC);
    write_reg(REG_SPARE_HI, 13'h0555);
    write_reg(REG_AUTO_BLACK, 13'h0FFF);
    write_reg(REG_CONTRAST, 13'h007F);
    write_reg(REG_NOISE_FLOOR, LVL_W'(-4096));
    batch = '{-4096, -3864, -3633, 4095};
    send_batch();

    write_reg(REG_COLOR_SCHEME, 13'd7);
    write_reg(REG_AUTO_BLACK, 13'd0);
    write_reg(REG_CONTRAST, 13'd0);
    write_reg(REG_BLACK_SHIFT, 13'd127);
    write_reg(REG_FLOOR_LEVEL, LVL_W'(-4096));
    batch = '{-4096, -3296, -2656, 0};
    send_batch();

    write_reg(REG_COLOR_SCHEME, LVL_W'(SCHEME_FIRE));
    write_reg(REG_CONTRAST, 13'd100);
    write_reg(REG_BLACK_SHIFT, 13'd100);
    write_reg(REG_FLOOR_LEVEL, LVL_W'(4095));
    batch = '{4095, -4096};
    send_batch();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      randomize_regs();
      batch.delete();
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) batch.push_back(level_t'($urandom));
        else batch.push_back(shadow.near_window());
      end
      send_batch();
    end

    repeat (40) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending_colors.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/wlc_pkg.sv
src/wlc_front.sv
src/wlc_queue.sv
src/wlc_back.sv
src/waterfall_level_colormap.sv
src/wlc_checker.sv
tb/tb_waterfall_level_colormap.sv
